// ===== rtl/core/gqb_pkg.sv =====
// Shared types and constants of the glyph quad builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gqb_pkg;

  // Table size default, used by the top level and the glyph table
  localparam int GQB_GLYPH_ENTRIES = 256;

  // Field widths
  localparam int MODE_W    = 2;
  localparam int CODE_W    = 8;
  localparam int ATLAS_W   = 12;
  localparam int TEXEL_W   = 13;  // atlas coordinate plus glyph size, and texture size
  localparam int BYTE_W    = 8;
  localparam int ORIGIN_W  = 16;
  localparam int SCALE_W   = 16;
  localparam int POS_W     = 21;
  localparam int TEX_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int VIDX_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int TERM_N_W  = 10;  // signed texel count: -128 .. 382

  // Texture divider: quotient bits resolved per cycle and steps per divide
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = FRAC_W / DIV_BITS;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  // Reset values and limits
  localparam logic [TEXEL_W-1:0] TEX_SIZE_RESET = 13'd256;
  localparam logic [SCALE_W-1:0] SCALE_ONE      = 16'd4096;
  localparam logic [TEX_W-1:0]   TEX_ONE        = 17'd65536;
  localparam logic signed [POS_W-1:0] POS_MAX   = 21'sh0FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN   = 21'sh100000;

  // One glyph table entry
  typedef struct packed {
    logic [BYTE_W-1:0]  advance;
    logic [BYTE_W-1:0]  offset_y;
    logic [BYTE_W-1:0]  offset_x;
    logic [BYTE_W-1:0]  glyph_height;
    logic [BYTE_W-1:0]  glyph_width;
    logic [ATLAS_W-1:0] atlas_y;
    logic [ATLAS_W-1:0] atlas_x;
  } glyph_entry_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/glyph_quad_builder_top.sv =====
// Glyph quad builder top level: sequencer, pen state, glyph table, dividers.
// Depends on gqb_pkg, gqb_glyph_mem, gqb_tex_div and gqb_pos_unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in_     | input     | in_valid / in_stall | mode, char code, glyph, origin, scale
//   out_    | output    | out_valid/out_stall | vertex x/y, tex u/v, index, last
//   cfg_    | input     | cfg_valid/cfg_ready | register index, write data
//
// Glyph loads, string starts and unused modes leave the sequencer idle.
// A character is accepted, read from the glyph table, run through the shared
// multiplier (its first four steps also run the 4-bit-per-cycle texture
// dividers) and sent one vertex per cycle into the output register.
// A stalled output holds the vertex sequence; the last vertex may wait while the
// next request is taken. Reset is synchronous; the glyph table is not cleared.
`default_nettype none

module glyph_quad_builder_top import gqb_pkg::*; #(
  parameter int GLYPH_ENTRIES = GQB_GLYPH_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [CODE_W-1:0]          in_char_code,
  input  logic [ATLAS_W-1:0]         in_atlas_x,
  input  logic [ATLAS_W-1:0]         in_atlas_y,
  input  logic [BYTE_W-1:0]          in_glyph_width,
  input  logic [BYTE_W-1:0]          in_glyph_height,
  input  logic signed [BYTE_W-1:0]   in_offset_x,
  input  logic signed [BYTE_W-1:0]   in_offset_y,
  input  logic [BYTE_W-1:0]          in_advance,
  input  logic signed [ORIGIN_W-1:0] in_origin_x,
  input  logic signed [ORIGIN_W-1:0] in_origin_y,
  input  logic [SCALE_W-1:0]         in_text_scale,
  // Vertex channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [POS_W-1:0]    out_vertex_x,
  output logic signed [POS_W-1:0]    out_vertex_y,
  output logic [TEX_W-1:0]           out_tex_u,
  output logic [TEX_W-1:0]           out_tex_v,
  output logic [VIDX_W-1:0]          out_vertex_index,
  output logic                       out_last_vertex,
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [TEXEL_W-1:0]         cfg_data
);

  localparam int IDX_W = $clog2(GLYPH_ENTRIES);

  // Sequencer steps
  localparam logic [2:0] STEP_LEFT   = 3'd0;
  localparam logic [2:0] STEP_RIGHT  = 3'd1;
  localparam logic [2:0] STEP_TOP    = 3'd2;
  localparam logic [2:0] STEP_BOTTOM = 3'd3;
  localparam logic [2:0] STEP_PEN    = 3'd4;
  localparam logic [2:0] STEP_LAST   = 3'd5;
  localparam logic [VIDX_W-1:0] VTX_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]               step_r;
  logic [VIDX_W-1:0]        vidx_r;
  logic signed [POS_W-1:0]  pen_x_r;
  logic signed [ORIGIN_W-1:0] pen_y_r;
  logic [SCALE_W-1:0]       scale_r;
  logic [TEXEL_W-1:0]       tex_w_r;
  logic [TEXEL_W-1:0]       tex_h_r;
  logic signed [POS_W-1:0]  xl_r, xr_r, yt_r, yb_r;

  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_x_r, out_y_r;
  logic [TEX_W-1:0]         out_u_r, out_v_r;
  logic [VIDX_W-1:0]        out_idx_r;
  logic                     out_last_r;

  logic                     in_accept;
  logic                     code_ok;
  logic                     emit_load;
  glyph_entry_t             wr_entry;
  glyph_entry_t             entry;
  div_ctrl_t                div_ctrl;
  logic [TEXEL_W-1:0]       div_w, div_h;
  logic [TEX_W-1:0]         ul, ur, vt, vb;
  logic signed [TERM_N_W-1:0] ox_n, oy_n;
  logic signed [TERM_N_W-1:0] pos_n;
  logic signed [POS_W-1:0]  pos_base;
  logic                     pos_neg;
  logic                     pos_issue;
  logic signed [POS_W-1:0]  pos_res;
  logic                     vtx_left, vtx_top;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign code_ok   = (int'(in_char_code) < GLYPH_ENTRIES);
  assign cfg_ready = 1'b1;

  // Glyph table; a load retires before any later read is issued
  assign wr_entry = '{advance:      in_advance,
                      offset_y:     in_offset_y,
                      offset_x:     in_offset_x,
                      glyph_height: in_glyph_height,
                      glyph_width:  in_glyph_width,
                      atlas_y:      in_atlas_y,
                      atlas_x:      in_atlas_x};

  gqb_glyph_mem #(
    .ENTRIES (GLYPH_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_glyph_mem (
    .clk     (clk),
    .wr_en   (in_accept && (in_mode == MODE_LOAD) && code_ok),
    .wr_addr (in_char_code[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (in_accept && (in_mode == MODE_CHAR) && code_ok),
    .rd_addr (in_char_code[IDX_W-1:0]),
    .rd_data (entry)
  );

  // Texture dividers; a zero size divides as one
  assign div_w = (tex_w_r == '0) ? TEXEL_W'(1) : tex_w_r;
  assign div_h = (tex_h_r == '0) ? TEXEL_W'(1) : tex_h_r;
  assign div_ctrl.start = (state_r == ST_LOOKUP);
  assign div_ctrl.step  = (state_r == ST_CALC) && (int'(step_r) < DIV_STEPS);

  gqb_tex_div u_div_ul (
    .clk  (clk), .ctrl (div_ctrl),
    .t    (TEXEL_W'(entry.atlas_x)), .d (div_w), .q (ul)
  );
  gqb_tex_div u_div_ur (
    .clk  (clk), .ctrl (div_ctrl),
    .t    (TEXEL_W'(entry.atlas_x) + TEXEL_W'(entry.glyph_width)), .d (div_w), .q (ur)
  );
  gqb_tex_div u_div_vt (
    .clk  (clk), .ctrl (div_ctrl),
    .t    (TEXEL_W'(entry.atlas_y)), .d (div_h), .q (vt)
  );
  gqb_tex_div u_div_vb (
    .clk  (clk), .ctrl (div_ctrl),
    .t    (TEXEL_W'(entry.atlas_y) + TEXEL_W'(entry.glyph_height)), .d (div_h), .q (vb)
  );

  // Select the texel count for this step of the shared multiplier
  assign ox_n = TERM_N_W'($signed(entry.offset_x));
  assign oy_n = TERM_N_W'($signed(entry.offset_y));
  assign pos_issue = (state_r == ST_CALC) && (step_r <= STEP_PEN);

  always_comb begin
    pos_n    = ox_n;
    pos_base = pen_x_r;
    pos_neg  = 1'b0;
    case (step_r)
      STEP_LEFT: begin
        pos_n = ox_n;
      end
      STEP_RIGHT: begin
        pos_n = ox_n + $signed(TERM_N_W'(entry.glyph_width));
      end
      STEP_TOP: begin
        pos_n    = oy_n;
        pos_base = POS_W'(pen_y_r);
        pos_neg  = 1'b1;
      end
      STEP_BOTTOM: begin
        pos_n    = oy_n + $signed(TERM_N_W'(entry.glyph_height));
        pos_base = POS_W'(pen_y_r);
        pos_neg  = 1'b1;
      end
      STEP_PEN: begin
        pos_n = $signed(TERM_N_W'(entry.advance));
      end
      default: begin
        pos_n = ox_n;
      end
    endcase
  end

  gqb_pos_unit u_pos_unit (
    .clk   (clk),
    .issue (pos_issue),
    .n     (pos_n),
    .scale (scale_r),
    .base  (pos_base),
    .neg   (pos_neg),
    .res   (pos_res)
  );

  // Capture each position one step after its multiply
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      case (step_r)
        STEP_RIGHT:  xl_r <= pos_res;
        STEP_TOP:    xr_r <= pos_res;
        STEP_BOTTOM: yt_r <= pos_res;
        STEP_PEN:    yb_r <= pos_res;
        default:     ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_CHAR) && code_ok) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && (vidx_r == VTX_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      vidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (state_r != ST_EMIT) begin
        vidx_r <= '0;
      end else if (emit_load) begin
        vidx_r <= vidx_r + VIDX_W'(1);
      end
    end
  end

  // Pen, scale and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      scale_r <= SCALE_ONE;
      tex_w_r <= TEX_SIZE_RESET;
      tex_h_r <= TEX_SIZE_RESET;
    end else begin
      if (in_accept && (in_mode == MODE_START)) begin
        pen_x_r <= POS_W'(in_origin_x);
        pen_y_r <= in_origin_y;
        scale_r <= in_text_scale;
      end else if ((state_r == ST_CALC) && (step_r == STEP_LAST)) begin
        pen_x_r <= pos_res;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEX_WIDTH:  tex_w_r <= cfg_data;
          REG_TEX_HEIGHT: tex_h_r <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  // Vertex order: 0 left/top, 1 right/top, 2 and 3 right/bottom,
  // 4 left/bottom, 5 left/top
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign vtx_left  = (vidx_r == 3'd0) || (vidx_r == 3'd4) || (vidx_r == 3'd5);
  assign vtx_top   = (vidx_r == 3'd0) || (vidx_r == 3'd1) || (vidx_r == 3'd5);

  // Output register: load a vertex when empty or draining, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x_r    <= vtx_left ? xl_r : xr_r;
      out_y_r    <= vtx_top  ? yt_r : yb_r;
      out_u_r    <= vtx_left ? ul   : ur;
      out_v_r    <= vtx_top  ? vt   : vb;
      out_idx_r  <= vidx_r;
      out_last_r <= (vidx_r == VTX_LAST);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_x     = out_x_r;
  assign out_vertex_y     = out_y_r;
  assign out_tex_u        = out_u_r;
  assign out_tex_v        = out_v_r;
  assign out_vertex_index = out_idx_r;
  assign out_last_vertex  = out_last_r;

  // Checks
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_vertex == (out_vertex_index == VTX_LAST)))
    else $error("last vertex flag out of step with vertex index");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_tex_u <= TEX_ONE) && (out_tex_v <= TEX_ONE)))
    else $error("texture coordinate above one");

  a_char_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_mode == MODE_CHAR) && code_ok) |=> (state_r == ST_LOOKUP))
    else $error("character request did not start a table read");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (step_r <= STEP_LAST))
    else $error("calculation step out of range");

endmodule

`default_nettype wire

// ===== rtl/core/gqb_glyph_mem.sv =====
// Glyph table: single-port-write, registered-read synchronous memory.
// Depends on gqb_pkg for the entry type.
`default_nettype none

module gqb_glyph_mem import gqb_pkg::*; #(
  parameter int ENTRIES = GQB_GLYPH_ENTRIES,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  glyph_entry_t     wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output glyph_entry_t     rd_data
);

  glyph_entry_t mem [ENTRIES];
  glyph_entry_t rd_data_r;

  // Write an entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/gqb_tex_div.sv =====
// Iterative texture coordinate divider: round(t * 65536 / d), clamped to 1.0.
// Resolves DIV_BITS quotient bits per step; depends on gqb_pkg.
`default_nettype none

module gqb_tex_div import gqb_pkg::*; (
  input  logic               clk,
  input  div_ctrl_t          ctrl,
  input  logic [TEXEL_W-1:0] t,
  input  logic [TEXEL_W-1:0] d,
  output logic [TEX_W-1:0]   q
);

  logic [TEXEL_W-1:0]  rem_r;
  logic [FRAC_W-1:0]   low_r;
  logic [FRAC_W-1:0]   quo_r;
  logic                sat_r;
  logic [TEXEL_W-1:0]  rem_nxt;
  logic [DIV_BITS-1:0] qbits;
  logic [TEXEL_W:0]    trial;

  // Restoring division, DIV_BITS bits of the numerator per step
  always_comb begin
    rem_nxt = rem_r;
    qbits   = '0;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_nxt, low_r[FRAC_W-1-i]};
      if (trial >= {1'b0, d}) begin
        trial = trial - {1'b0, d};
        qbits[DIV_BITS-1-i] = 1'b1;
      end
      rem_nxt = trial[TEXEL_W-1:0];
    end
  end

  // Numerator is t * 65536 + d/2; t >= d always gives a quotient of 1.0 or more
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sat_r <= (t >= d);
      rem_r <= t;
      low_r <= FRAC_W'(d[TEXEL_W-1:1]);
      quo_r <= '0;
    end else if (ctrl.step) begin
      rem_r <= rem_nxt;
      low_r <= low_r << DIV_BITS;
      quo_r <= {quo_r[FRAC_W-DIV_BITS-1:0], qbits};
    end
  end

  assign q = sat_r ? TEX_ONE : {1'b0, quo_r};

endmodule

`default_nettype wire

// ===== rtl/core/gqb_pos_unit.sv =====
// Screen position unit: texel count times scale, rounded to Q.4, added to or
// subtracted from the pen and saturated to Q16.4. Depends on gqb_pkg.
`default_nettype none

module gqb_pos_unit import gqb_pkg::*; (
  input  logic                       clk,
  input  logic                       issue,
  input  logic signed [TERM_N_W-1:0] n,
  input  logic [SCALE_W-1:0]         scale,
  input  logic signed [POS_W-1:0]    base,
  input  logic                       neg,
  output logic signed [POS_W-1:0]    res
);

  localparam int PROD_W = TERM_N_W + SCALE_W + 1;
  localparam int TERM_W = PROD_W - 8;
  localparam int SUM_W  = POS_W + 2;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [POS_W-1:0]  base_r;
  logic                     neg_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sum;

  // Multiply stage; both operands widened to the full product first
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= PROD_W'(n) * PROD_W'($signed({1'b0, scale}));
      base_r <= base;
      neg_r  <= neg;
    end
  end

  // Round to nearest (ties up) from Q.12 to Q.4, then add and saturate
  always_comb begin
    rnd  = prod_r + PROD_W'(128);
    term = $signed(rnd[PROD_W-1:8]);
    if (neg_r) begin
      sum = SUM_W'(base_r) - SUM_W'(term);
    end else begin
      sum = SUM_W'(base_r) + SUM_W'(term);
    end
    if (sum > SUM_W'(POS_MAX)) begin
      res = POS_MAX;
    end else if (sum < SUM_W'(POS_MIN)) begin
      res = POS_MIN;
    end else begin
      res = sum[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the glyph quad builder: glyph loads, string starts
// and characters go in, and every vertex that comes out is checked against a
// predicted one. Depends on gqb_pkg and glyph_quad_builder_top.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gqb_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ROUNDS = 4;
  localparam int ROUND_ITEMS   = 64;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic [CODE_W-1:0]          code;
    logic [ATLAS_W-1:0]         atlas_x;
    logic [ATLAS_W-1:0]         atlas_y;
    logic [BYTE_W-1:0]          glyph_width;
    logic [BYTE_W-1:0]          glyph_height;
    logic signed [BYTE_W-1:0]   offset_x;
    logic signed [BYTE_W-1:0]   offset_y;
    logic [BYTE_W-1:0]          advance;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [SCALE_W-1:0]         text_scale;
  } glyph_request_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
    logic [VIDX_W-1:0]       index;
    logic                    last;
  } vertex_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [MODE_W-1:0]          in_mode;
  logic [CODE_W-1:0]          in_char_code;
  logic [ATLAS_W-1:0]         in_atlas_x;
  logic [ATLAS_W-1:0]         in_atlas_y;
  logic [BYTE_W-1:0]          in_glyph_width;
  logic [BYTE_W-1:0]          in_glyph_height;
  logic signed [BYTE_W-1:0]   in_offset_x;
  logic signed [BYTE_W-1:0]   in_offset_y;
  logic [BYTE_W-1:0]          in_advance;
  logic signed [ORIGIN_W-1:0] in_origin_x;
  logic signed [ORIGIN_W-1:0] in_origin_y;
  logic [SCALE_W-1:0]         in_text_scale;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [POS_W-1:0]    out_vertex_x;
  logic signed [POS_W-1:0]    out_vertex_y;
  logic [TEX_W-1:0]           out_tex_u;
  logic [TEX_W-1:0]           out_tex_v;
  logic [VIDX_W-1:0]          out_vertex_index;
  logic                       out_last_vertex;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [TEXEL_W-1:0]         cfg_data;

  glyph_quad_builder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_atlas_x       (in_atlas_x),
    .in_atlas_y       (in_atlas_y),
    .in_glyph_width   (in_glyph_width),
    .in_glyph_height  (in_glyph_height),
    .in_offset_x      (in_offset_x),
    .in_offset_y      (in_offset_y),
    .in_advance       (in_advance),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_text_scale    (in_text_scale),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_vertex_index (out_vertex_index),
    .out_last_vertex  (out_last_vertex),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Shadow of the block: glyph table, pen, scale and texture size
  glyph_entry_t glyph_shadow [GQB_GLYPH_ENTRIES];
  bit           glyph_loaded [GQB_GLYPH_ENTRIES];
  int           loaded_codes [$];
  longint       pen_x_q;
  longint       pen_y_q;
  longint       scale_q;
  longint       tex_width_q;
  longint       tex_height_q;

  vertex_t      vertex_q [$];
  int           errors;
  int           next_gap;
  bit           no_idle;
  int           long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Scaled texel count in Q.4, rounded to nearest with ties upward
  function automatic longint pos_term(longint texels);
    return (texels * scale_q + 128) >>> 8;
  endfunction

  function automatic longint sat_pos(longint value);
    if (value > longint'(POS_MAX)) return longint'(POS_MAX);
    if (value < longint'(POS_MIN)) return longint'(POS_MIN);
    return value;
  endfunction

  // Texel coordinate over atlas size in Q1.16; a zero size divides as one
  function automatic longint tex_coord(longint texel, longint size);
    longint d;
    longint q;
    d = (size == 0) ? 1 : size;
    q = (texel * longint'(TEX_ONE) + d / 2) / d;
    return (q > longint'(TEX_ONE)) ? longint'(TEX_ONE) : q;
  endfunction

  // Update the shadow for one accepted request and queue the vertices it yields
  task automatic predict_request(glyph_request_t r);
    glyph_entry_t e;
    longint       ox, oy, xl, xr, yt, yb, ul, ur, vt, vb;
    vertex_t      vx;
    bit           right, bottom;
    case (r.mode)
      MODE_LOAD: begin
        glyph_shadow[r.code] = '{advance: r.advance, offset_y: r.offset_y,
                                 offset_x: r.offset_x, glyph_height: r.glyph_height,
                                 glyph_width: r.glyph_width, atlas_y: r.atlas_y,
                                 atlas_x: r.atlas_x};
        if (!glyph_loaded[r.code]) begin
          glyph_loaded[r.code] = 1'b1;
          loaded_codes.push_back(int'(r.code));
        end
      end
      MODE_START: begin
        pen_x_q = longint'(r.origin_x);
        pen_y_q = longint'(r.origin_y);
        scale_q = longint'(r.text_scale);
      end
      MODE_CHAR: begin
        e  = glyph_shadow[r.code];
        ox = longint'($signed(e.offset_x));
        oy = longint'($signed(e.offset_y));
        xl = sat_pos(pen_x_q + pos_term(ox));
        xr = sat_pos(pen_x_q + pos_term(longint'(e.glyph_width) + ox));
        yt = sat_pos(pen_y_q - pos_term(oy));
        yb = sat_pos(pen_y_q - pos_term(longint'(e.glyph_height) + oy));
        ul = tex_coord(longint'(e.atlas_x), tex_width_q);
        ur = tex_coord(longint'(e.atlas_x) + longint'(e.glyph_width), tex_width_q);
        vt = tex_coord(longint'(e.atlas_y), tex_height_q);
        vb = tex_coord(longint'(e.atlas_y) + longint'(e.glyph_height), tex_height_q);
        // Triangles 0-1-2 and 2-4-0 walked as six corners
        for (int k = 0; k < 6; k++) begin
          right    = (k >= 1) && (k <= 3);
          bottom   = (k >= 2) && (k <= 4);
          vx.x     = POS_W'(right ? xr : xl);
          vx.u     = TEX_W'(right ? ur : ul);
          vx.y     = POS_W'(bottom ? yb : yt);
          vx.v     = TEX_W'(bottom ? vb : vt);
          vx.index = VIDX_W'(k);
          vx.last  = (k == 5);
          vertex_q.push_back(vx);
        end
        pen_x_q = sat_pos(pen_x_q + pos_term(longint'(e.advance)));
      end
      default: ;
    endcase
  endtask

  // Send one request; valid stays high when the next one follows at once
  task automatic send_request(glyph_request_t r);
    repeat (next_gap) @(posedge clk);
    in_mode         <= r.mode;
    in_char_code    <= r.code;
    in_atlas_x      <= r.atlas_x;
    in_atlas_y      <= r.atlas_y;
    in_glyph_width  <= r.glyph_width;
    in_glyph_height <= r.glyph_height;
    in_offset_x     <= r.offset_x;
    in_offset_y     <= r.offset_y;
    in_advance      <= r.advance;
    in_origin_x     <= r.origin_x;
    in_origin_y     <= r.origin_y;
    in_text_scale   <= r.text_scale;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_request(r);
    next_gap = no_idle ? 0 : $urandom_range(0, 7);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  function automatic glyph_request_t random_request();
    glyph_request_t r;
    r.mode         = MODE_W'($urandom);
    r.code         = CODE_W'($urandom);
    r.atlas_x      = ATLAS_W'($urandom);
    r.atlas_y      = ATLAS_W'($urandom);
    r.glyph_width  = BYTE_W'($urandom);
    r.glyph_height = BYTE_W'($urandom);
    r.offset_x     = BYTE_W'($urandom);
    r.offset_y     = BYTE_W'($urandom);
    r.advance      = BYTE_W'($urandom);
    r.origin_x     = ORIGIN_W'($urandom);
    r.origin_y     = ORIGIN_W'($urandom);
    r.text_scale   = SCALE_W'($urandom);
    return r;
  endfunction

  task automatic send_load(int code, int ax, int ay, int gw, int gh, int ox, int oy,
                           int adv);
    glyph_request_t r;
    r              = random_request();
    r.mode         = MODE_LOAD;
    r.code         = CODE_W'(code);
    r.atlas_x      = ATLAS_W'(ax);
    r.atlas_y      = ATLAS_W'(ay);
    r.glyph_width  = BYTE_W'(gw);
    r.glyph_height = BYTE_W'(gh);
    r.offset_x     = BYTE_W'(ox);
    r.offset_y     = BYTE_W'(oy);
    r.advance      = BYTE_W'(adv);
    send_request(r);
  endtask

  task automatic send_start(int ox, int oy, int scale);
    glyph_request_t r;
    r            = random_request();
    r.mode       = MODE_START;
    r.origin_x   = ORIGIN_W'(ox);
    r.origin_y   = ORIGIN_W'(oy);
    r.text_scale = SCALE_W'(scale);
    send_request(r);
  endtask

  task automatic send_char(int code);
    glyph_request_t r;
    r      = random_request();
    r.mode = MODE_CHAR;
    r.code = CODE_W'(code);
    send_request(r);
  endtask

  // Drop valid, wait for every vertex, then let the pipeline settle
  task automatic drain();
    if (next_gap == 0) in_valid <= 1'b0;
    next_gap = 0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; valid is left high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TEXEL_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEX_WIDTH:  tex_width_q  = longint'(data);
      REG_TEX_HEIGHT: tex_height_q = longint'(data);
      default: ;
    endcase
  endtask

  // Set both atlas sizes, with a write to an unused index in between
  task automatic set_texture(int width, int height);
    write_reg(REG_TEX_WIDTH, TEXEL_W'(width));
    write_reg($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2, TEXEL_W'($urandom));
    write_reg(REG_TEX_HEIGHT, TEXEL_W'(height));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: hold off for a drawn number of cycles after each vertex
  initial begin
    int w;
    out_stall <= 1'b0;
    forever begin
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      if (long_hold != 0) begin
        w         = long_hold;
        long_hold = 0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(string field, longint expected, longint actual);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
             actual);
    errors++;
  endtask

  // Compare each accepted vertex with the oldest prediction
  always @(posedge clk) begin : vertex_check
    vertex_t exp_v;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: vertex with none expected, x %0d y %0d index %0d", $time,
                 out_vertex_x, out_vertex_y, out_vertex_index);
        errors++;
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_vertex_x !== exp_v.x)
          note_mismatch("vertex_x", longint'(exp_v.x), longint'(out_vertex_x));
        if (out_vertex_y !== exp_v.y)
          note_mismatch("vertex_y", longint'(exp_v.y), longint'(out_vertex_y));
        if (out_tex_u !== exp_v.u)
          note_mismatch("tex_u", longint'(exp_v.u), longint'(out_tex_u));
        if (out_tex_v !== exp_v.v)
          note_mismatch("tex_v", longint'(exp_v.v), longint'(out_tex_v));
        if (out_vertex_index !== exp_v.index)
          note_mismatch("vertex_index", longint'(exp_v.index),
                        longint'(out_vertex_index));
        if (out_last_vertex !== exp_v.last)
          note_mismatch("last_vertex", longint'(exp_v.last), longint'(out_last_vertex));
      end
    end
  end

  // Characters straight after reset use the reset scale and atlas size
  task automatic test_reset_state();
    send_load(65, 16, 32, 8, 12, 1, 10, 9);
    send_char(65);
    send_char(65);
    drain();
  endtask

  // Field extremes, both scale ends, and a request of the unused mode
  task automatic test_field_extremes();
    glyph_request_t r;
    send_load(0, 0, 0, 0, 0, 0, 0, 0);
    send_load(255, 4095, 4095, 255, 255, -128, -128, 255);
    send_load(128, 4000, 100, 255, 1, 127, 127, 128);
    send_start(-32768, -32768, 65535);
    send_char(255);
    send_char(128);
    send_char(0);
    r      = random_request();
    r.mode = MODE_SPARE;
    send_request(r);
    send_start(32767, 32767, 0);
    send_char(255);
    drain();
  endtask

  // Atlas sizes at the extremes, zero included, coordinates past the edge
  task automatic test_texture_sizes();
    int sizes [5][2];
    sizes = '{'{1, 1}, '{4096, 4096}, '{0, 0}, '{8191, 1}, '{0, 0}};
    sizes[4] = '{$urandom_range(1, 4096), $urandom_range(1, 4096)};
    foreach (sizes[i]) begin
      set_texture(sizes[i][0], sizes[i][1]);
      send_char(255);
      send_char((i % 2 != 0) ? 128 : 0);
      drain();
    end
  endtask

  // Strings of loaded glyphs with random content, some loads and noise
  task automatic test_random_strings();
    glyph_request_t r;
    int             pick;
    int             sent;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      set_texture($urandom_range(1, 4096), $urandom_range(1, 4096));
      no_idle = (round == 2);
      sent    = 0;
      while (sent < ROUND_ITEMS) begin
        r    = random_request();
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          r.mode = MODE_SPARE;
        end else if (pick < 14 || loaded_codes.size() == 0) begin
          r.mode = MODE_LOAD;
        end else if (pick < 24) begin
          r.mode = MODE_START;
          if ($urandom_range(0, 4) != 0) r.text_scale = SCALE_W'($urandom_range(0, 8192));
        end else begin
          r.mode = MODE_CHAR;
          r.code = CODE_W'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
        end
        send_request(r);
        if (r.mode != MODE_SPARE) sent++;
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // Long receiver hold while characters keep coming; the pen saturates too
  task automatic test_output_backpressure();
    no_idle   = 1'b1;
    long_hold = 300;
    send_start(32767, 0, 65535);
    repeat (24) send_char(255);
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    errors       = 0;
    next_gap     = 0;
    no_idle      = 1'b0;
    long_hold    = 0;
    pen_x_q      = 0;
    pen_y_q      = 0;
    scale_q      = longint'(SCALE_ONE);
    tex_width_q  = longint'(TEX_SIZE_RESET);
    tex_height_q = longint'(TEX_SIZE_RESET);

    // Hold every input at a known value through reset
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_LOAD;
    in_char_code    <= '0;
    in_atlas_x      <= '0;
    in_atlas_y      <= '0;
    in_glyph_width  <= '0;
    in_glyph_height <= '0;
    in_offset_x     <= '0;
    in_offset_y     <= '0;
    in_advance      <= '0;
    in_origin_x     <= '0;
    in_origin_y     <= '0;
    in_text_scale   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_TEX_WIDTH;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_field_extremes();
    test_texture_sizes();
    test_random_strings();
    test_output_backpressure();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== glyph_quad_builder_top.f =====
rtl/core/gqb_pkg.sv
rtl/core/gqb_glyph_mem.sv
rtl/core/gqb_tex_div.sv
rtl/core/gqb_pos_unit.sv
rtl/core/glyph_quad_builder_top.sv
sim/tb_top.sv
